FILE: design/vfm_pkg.sv
package vfm_pkg;

   localparam int COORD_W  = 5;
   localparam int VOX_AW   = 3 * COORD_W;
   localparam int VOX_W    = 7;
   localparam int MASK_AW  = 2 * COORD_W;
   localparam int KEY_W    = 16;
   localparam logic [KEY_W-1:0] KEY_NONE = 16'hFFFF;
   localparam logic [2:0] MAT_PALETTE = 3'd6;
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PULL  = 1'b1;
   localparam logic MODE_NAIVE  = 1'b0;
   localparam logic MODE_GREEDY = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [4:0] pos_x;
      logic [4:0] pos_y;
      logic [4:0] pos_z;
      logic [2:0] voxel_type;
      logic [7:0] color_index;
   } req_type;

   typedef struct packed {
      logic [4:0] vert_x;
      logic [4:0] vert_y;
      logic [4:0] vert_z;
      logic [2:0] face;
      logic [1:0] corner;
      logic [1:0] ao;
      logic [2:0] material;
      logic [3:0] color;
      logic       last_of_face;
      logic       done_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NNEXT,
      ST_PISSUE,
      ST_PTAKE,
      ST_GSTART,
      ST_GSCAN,
      ST_GKEY,
      ST_GWID,
      ST_GWIDT,
      ST_GGROW,
      ST_GGROWT,
      ST_GCLR,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PRB_CELL,
      PRB_NBR,
      PRB_AO
   } probe_type;

   // Corner offset bits of a quad, ordered {x, y, z}.
   function automatic logic [2:0] cax_bits(input logic [2:0] f, input logic [1:0] c);
      logic [2:0] r;
      case ({f, c})
         5'b000_00: r = 3'b100;
         5'b000_01: r = 3'b110;
         5'b000_10: r = 3'b111;
         5'b000_11: r = 3'b101;
         5'b001_00: r = 3'b001;
         5'b001_01: r = 3'b011;
         5'b001_10: r = 3'b010;
         5'b001_11: r = 3'b000;
         5'b010_00: r = 3'b010;
         5'b010_01: r = 3'b011;
         5'b010_10: r = 3'b111;
         5'b010_11: r = 3'b110;
         5'b011_00: r = 3'b001;
         5'b011_01: r = 3'b000;
         5'b011_10: r = 3'b100;
         5'b011_11: r = 3'b101;
         5'b100_00: r = 3'b101;
         5'b100_01: r = 3'b111;
         5'b100_10: r = 3'b011;
         5'b100_11: r = 3'b001;
         5'b101_00: r = 3'b000;
         5'b101_01: r = 3'b010;
         5'b101_10: r = 3'b110;
         5'b101_11: r = 3'b100;
         default:   r = 3'b000;
      endcase
      return r;
   endfunction

endpackage

FILE: design/voxel_face_mesher.sv
// Voxel face mesher for a 32x32x32 chunk. A write beat stores one voxel; a pull beat
// returns the next visible face as four vertex beats with per-corner ambient occlusion,
// or one done beat once the walk is exhausted. Any write restarts the walk. After reset
// all 32768 voxel memory entries are cleared, during which req_stall stays high.
// One item is worked at a time through the single read port of the voxel memory: every
// voxel lookup takes an issue state and a take state, so a naive face is a cell, a
// neighbour and twelve occlusion lookups followed by four output beats, and a skipped
// side stops after its cell or neighbour lookup. In greedy mode the first pull of a slice
// builds the slice's key mask (1024 cells), and each face then reads mask entries while
// merging and clears each entry that it merged.
module voxel_face_mesher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vfm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vfm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic                        mode_ff, mode_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   vfm_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                        out_free, beat_valid;
   vfm_pkg::rsp_type            beat;
   logic                        vox_we, mask_we;
   logic [vfm_pkg::VOX_AW-1:0]  vox_waddr, vox_raddr;
   logic [vfm_pkg::VOX_W-1:0]   vox_wdata, vox_rdata;
   logic [vfm_pkg::MASK_AW-1:0] mask_waddr, mask_raddr;
   logic [vfm_pkg::KEY_W-1:0]   mask_wdata, mask_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mode_in = csr_we ? csr_wdata : mode_ff;
      rsp_valid_in = beat_valid || (rsp_valid_ff && rsp_stall);
      rsp_data_in = beat_valid ? beat : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vfm_pkg::MODE_NAIVE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   vfm_ram #(.ADDR_W(vfm_pkg::VOX_AW), .DATA_W(vfm_pkg::VOX_W)) u_vox_ram (
      .clock   (clock),
      .wr_en   (vox_we),
      .wr_addr (vox_waddr),
      .wr_data (vox_wdata),
      .rd_addr (vox_raddr),
      .rd_data (vox_rdata)
   );

   vfm_ram #(.ADDR_W(vfm_pkg::MASK_AW), .DATA_W(vfm_pkg::KEY_W)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (mask_waddr),
      .wr_data (mask_wdata),
      .rd_addr (mask_raddr),
      .rd_data (mask_rdata)
   );

   vfm_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .csr_we     (csr_we),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .out_free   (out_free),
      .beat_valid (beat_valid),
      .beat       (beat),
      .vox_we     (vox_we),
      .vox_waddr  (vox_waddr),
      .vox_wdata  (vox_wdata),
      .vox_raddr  (vox_raddr),
      .vox_rdata  (vox_rdata),
      .mask_we    (mask_we),
      .mask_waddr (mask_waddr),
      .mask_wdata (mask_wdata),
      .mask_raddr (mask_raddr),
      .mask_rdata (mask_rdata)
   );

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.last_of_face)
      else $error("done beat without last_of_face");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.material == 3'd0 &&
      rsp_data.vert_x == 5'd0 && rsp_data.face == 3'd0 && rsp_data.ao == 2'd0)
      else $error("done beat carries face data");

   a_face_solid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.material != 3'd0)
      else $error("face beat of an empty voxel");

endmodule

FILE: design/vfm_ram.sv
module vfm_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/vfm_walker.sv
module vfm_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mode,
   input  logic                          csr_we,
   input  logic                          req_valid,
   input  vfm_pkg::req_type              req_data,
   output logic                          req_stall,
   input  logic                          out_free,
   output logic                          beat_valid,
   output vfm_pkg::rsp_type              beat,
   output logic                          vox_we,
   output logic [vfm_pkg::VOX_AW-1:0]    vox_waddr,
   output logic [vfm_pkg::VOX_W-1:0]     vox_wdata,
   output logic [vfm_pkg::VOX_AW-1:0]    vox_raddr,
   input  logic [vfm_pkg::VOX_W-1:0]     vox_rdata,
   output logic                          mask_we,
   output logic [vfm_pkg::MASK_AW-1:0]   mask_waddr,
   output logic [vfm_pkg::KEY_W-1:0]     mask_wdata,
   output logic [vfm_pkg::MASK_AW-1:0]   mask_raddr,
   input  logic [vfm_pkg::KEY_W-1:0]     mask_rdata
);

   vfm_pkg::state_type state_ff, state_in;
   vfm_pkg::probe_type prb_ff, prb_in;
   logic [2:0]  face_ff, face_in;
   logic [4:0]  slice_ff, slice_in, u_ff, u_in, v_ff, v_in, row_ff, row_in;
   logic        fin_ff, fin_in, mready_ff, mready_in;
   logic [1:0]  cn_ff, cn_in, wh_ff, wh_in, em_ff, em_in;
   logic        sa_ff, sa_in, sb_ff, sb_in, oob_ff, oob_in;
   logic [7:0]  sig_ff, sig_in;
   logic [6:0]  cv_ff, cv_in;
   logic [15:0] key_ff, key_in;
   logic [5:0]  w_ff, w_in, h_ff, h_in;
   logic [4:0]  i_ff, i_in, j_ff, j_in;
   logic [14:0] clr_ff, clr_in;

   logic [1:0]        p, ua, va;
   logic [4:0]        base [3];
   logic [4:0]        vbase [3];
   logic signed [6:0] off [3];
   logic signed [6:0] pos [3];
   logic [2:0]        cax, ecax;
   logic              oob, solid;
   logic [1:0]        occ;
   logic [5:0]        usum, uw, vh, ip1, jp1;
   logic [4:0]        ui;
   logic [7:0]        nkey_sig;

   assign p  = face_ff[2:1];
   assign ua = (p == 2'd0) ? 2'd1 : 2'd0;
   assign va = (p == 2'd2) ? 2'd1 : 2'd2;
   assign cax  = vfm_pkg::cax_bits(face_ff, cn_ff);
   assign ecax = vfm_pkg::cax_bits(face_ff, em_ff);
   assign usum = {1'b0, u_ff} + w_ff;
   assign uw   = usum;
   assign vh   = {1'b0, v_ff} + h_ff;
   assign ip1  = {1'b0, i_ff} + 6'd1;
   assign jp1  = {1'b0, j_ff} + 6'd1;
   assign ui   = u_ff + i_ff;
   assign solid = !oob_ff && (vox_rdata[6:4] != 3'd0);

   always_comb begin
      if (mode == vfm_pkg::MODE_NAIVE) begin
         base[0] = u_ff;
         base[1] = slice_ff;
         base[2] = row_ff;
      end else begin
         case (p)
            2'd0: begin
               base[0] = slice_ff;
               base[1] = u_ff;
               base[2] = v_ff;
            end
            2'd1: begin
               base[0] = u_ff;
               base[1] = slice_ff;
               base[2] = v_ff;
            end
            default: begin
               base[0] = u_ff;
               base[1] = v_ff;
               base[2] = slice_ff;
            end
         endcase
      end
      for (int a = 0; a < 3; a++) begin
         off[a] = 7'sd0;
         if (prb_ff != vfm_pkg::PRB_CELL && p == 2'(a)) begin
            off[a] = face_ff[0] ? -7'sd1 : 7'sd1;
         end
         if (prb_ff == vfm_pkg::PRB_AO) begin
            if (ua == 2'(a) && wh_ff != 2'd1) begin
               off[a] = off[a] + (cax[2-a] ? 7'sd1 : -7'sd1);
            end
            if (va == 2'(a) && wh_ff != 2'd0) begin
               off[a] = off[a] + (cax[2-a] ? 7'sd1 : -7'sd1);
            end
         end
         pos[a] = $signed({2'b00, base[a]}) + off[a];
         vbase[a] = base[a];
         if (ua == 2'(a) && ecax[2-a]) begin
            vbase[a] = base[a] + 5'(w_ff - 6'd1);
         end
         if (va == 2'(a) && ecax[2-a]) begin
            vbase[a] = base[a] + 5'(h_ff - 6'd1);
         end
      end
      oob = (|pos[0][6:5]) || (|pos[1][6:5]) || (|pos[2][6:5]);
      occ = (sa_ff && sb_ff) ? 2'd3 : 2'({1'b0, sa_ff} + {1'b0, sb_ff} + {1'b0, solid});
      nkey_sig = sig_ff;
      nkey_sig[{cn_ff, 1'b0} +: 2] = 2'd3 - occ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vfm_pkg::ST_CLEAR;
         clr_ff    <= '0;
         face_ff   <= '0;
         slice_ff  <= '0;
         u_ff      <= '0;
         v_ff      <= '0;
         row_ff    <= '0;
         fin_ff    <= 1'b0;
         mready_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         face_ff   <= face_in;
         slice_ff  <= slice_in;
         u_ff      <= u_in;
         v_ff      <= v_in;
         row_ff    <= row_in;
         fin_ff    <= fin_in;
         mready_ff <= mready_in;
      end
      prb_ff <= prb_in;
      cn_ff  <= cn_in;
      wh_ff  <= wh_in;
      em_ff  <= em_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      oob_ff <= oob_in;
      sig_ff <= sig_in;
      cv_ff  <= cv_in;
      key_ff <= key_in;
      w_ff   <= w_in;
      h_ff   <= h_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      face_in = face_ff;
      slice_in = slice_ff;
      u_in = u_ff;
      v_in = v_ff;
      row_in = row_ff;
      fin_in = fin_ff;
      mready_in = mready_ff;
      prb_in = prb_ff;
      cn_in = cn_ff;
      wh_in = wh_ff;
      em_in = em_ff;
      sa_in = sa_ff;
      sb_in = sb_ff;
      oob_in = oob;
      sig_in = sig_ff;
      cv_in = cv_ff;
      key_in = key_ff;
      w_in = w_ff;
      h_in = h_ff;
      i_in = i_ff;
      j_in = j_ff;
      req_stall = (state_ff != vfm_pkg::ST_IDLE);
      beat_valid = 1'b0;
      beat = '0;
      vox_we = 1'b0;
      vox_waddr = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
      vox_wdata = '0;
      vox_raddr = {pos[2][4:0], pos[1][4:0], pos[0][4:0]};
      mask_we = 1'b0;
      mask_waddr = {v_ff, u_ff};
      mask_wdata = vfm_pkg::KEY_NONE;
      mask_raddr = {v_ff, u_ff};

      case (state_ff)
         vfm_pkg::ST_CLEAR: begin
            vox_we = 1'b1;
            vox_waddr = clr_ff;
            clr_in = clr_ff + 15'd1;
            if (&clr_ff) begin
               state_in = vfm_pkg::ST_IDLE;
            end
         end
         vfm_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == vfm_pkg::KIND_WRITE) begin
                  vox_we = 1'b1;
                  if (req_data.voxel_type >= 3'd1 && req_data.voxel_type <= 3'd5) begin
                     vox_wdata = (req_data.color_index <= 8'd15) ?
                        {vfm_pkg::MAT_PALETTE, req_data.color_index[3:0]} :
                        {req_data.voxel_type, 4'd0};
                  end
                  face_in = '0;
                  slice_in = '0;
                  u_in = '0;
                  v_in = '0;
                  row_in = '0;
                  fin_in = 1'b0;
                  mready_in = 1'b0;
               end else begin
                  state_in = (mode == vfm_pkg::MODE_GREEDY) ? vfm_pkg::ST_GSTART :
                                                              vfm_pkg::ST_NNEXT;
               end
            end
         end
         vfm_pkg::ST_NNEXT: begin
            prb_in = vfm_pkg::PRB_CELL;
            state_in = fin_ff ? vfm_pkg::ST_DONE : vfm_pkg::ST_PISSUE;
         end
         vfm_pkg::ST_PISSUE: begin
            state_in = vfm_pkg::ST_PTAKE;
         end
         vfm_pkg::ST_PTAKE: begin
            state_in = vfm_pkg::ST_PISSUE;
            case (prb_ff)
               vfm_pkg::PRB_CELL: begin
                  cv_in = vox_rdata;
                  if (vox_rdata[6:4] == 3'd0 || oob_ff) begin
                     state_in = vfm_pkg::ST_NNEXT;
                  end else begin
                     prb_in = vfm_pkg::PRB_NBR;
                  end
               end
               vfm_pkg::PRB_NBR: begin
                  if (solid) begin
                     state_in = vfm_pkg::ST_NNEXT;
                  end else begin
                     prb_in = vfm_pkg::PRB_AO;
                     cn_in = 2'd0;
                     wh_in = 2'd0;
                  end
               end
               default: begin
                  wh_in = wh_ff + 2'd1;
                  if (wh_ff == 2'd0) begin
                     sa_in = solid;
                  end else if (wh_ff == 2'd1) begin
                     sb_in = solid;
                  end else begin
                     wh_in = 2'd0;
                     sig_in = nkey_sig;
                     cn_in = cn_ff + 2'd1;
                     if (cn_ff == 2'd3) begin
                        em_in = 2'd0;
                        state_in = (mode == vfm_pkg::MODE_GREEDY) ? vfm_pkg::ST_GSTART :
                                                                    vfm_pkg::ST_EMIT;
                     end
                  end
               end
            endcase
            // A miss advances the naive walk; the greedy build records the key instead.
            if (state_in != vfm_pkg::ST_PISSUE && !(state_in == vfm_pkg::ST_EMIT)) begin
               if (mode == vfm_pkg::MODE_NAIVE) begin
                  if (face_ff == 3'd5) begin
                     face_in = 3'd0;
                     if (u_ff == 5'd31) begin
                        u_in = 5'd0;
                        if (row_ff == 5'd31) begin
                           row_in = 5'd0;
                           if (slice_ff == 5'd31) begin
                              slice_in = 5'd0;
                              fin_in = 1'b1;
                           end else begin
                              slice_in = slice_ff + 5'd1;
                           end
                        end else begin
                           row_in = row_ff + 5'd1;
                        end
                     end else begin
                        u_in = u_ff + 5'd1;
                     end
                  end else begin
                     face_in = face_ff + 3'd1;
                  end
               end else begin
                  mask_we = 1'b1;
                  if (state_in == vfm_pkg::ST_GSTART) begin
                     mask_wdata = {1'b0, cv_ff[6:4], nkey_sig, cv_ff[3:0]};
                  end
                  prb_in = vfm_pkg::PRB_CELL;
                  state_in = vfm_pkg::ST_PISSUE;
                  if (u_ff == 5'd31) begin
                     u_in = 5'd0;
                     if (v_ff == 5'd31) begin
                        v_in = 5'd0;
                        mready_in = 1'b1;
                        state_in = vfm_pkg::ST_GSCAN;
                     end else begin
                        v_in = v_ff + 5'd1;
                     end
                  end else begin
                     u_in = u_ff + 5'd1;
                  end
               end
            end
         end
         vfm_pkg::ST_GSTART: begin
            prb_in = vfm_pkg::PRB_CELL;
            if (fin_ff) begin
               state_in = vfm_pkg::ST_DONE;
            end else if (!mready_ff) begin
               state_in = vfm_pkg::ST_PISSUE;
            end else begin
               state_in = vfm_pkg::ST_GSCAN;
            end
         end
         vfm_pkg::ST_GSCAN: begin
            state_in = vfm_pkg::ST_GKEY;
         end
         vfm_pkg::ST_GKEY: begin
            key_in = mask_rdata;
            w_in = 6'd1;
            if (mask_rdata != vfm_pkg::KEY_NONE) begin
               state_in = vfm_pkg::ST_GWID;
            end else begin
               state_in = vfm_pkg::ST_GSCAN;
               if (u_ff == 5'd31) begin
                  u_in = 5'd0;
                  if (v_ff == 5'd31) begin
                     v_in = 5'd0;
                     mready_in = 1'b0;
                     state_in = vfm_pkg::ST_GSTART;
                     if (slice_ff == 5'd31) begin
                        slice_in = 5'd0;
                        if (face_ff == 3'd5) begin
                           face_in = 3'd0;
                           fin_in = 1'b1;
                        end else begin
                           face_in = face_ff + 3'd1;
                        end
                     end else begin
                        slice_in = slice_ff + 5'd1;
                     end
                  end else begin
                     v_in = v_ff + 5'd1;
                  end
               end else begin
                  u_in = u_ff + 5'd1;
               end
            end
         end
         vfm_pkg::ST_GWID: begin
            mask_raddr = {v_ff, uw[4:0]};
            h_in = 6'd1;
            i_in = 5'd0;
            state_in = uw[5] ? vfm_pkg::ST_GGROW : vfm_pkg::ST_GWIDT;
         end
         vfm_pkg::ST_GWIDT: begin
            if (mask_rdata == key_ff) begin
               w_in = w_ff + 6'd1;
               state_in = vfm_pkg::ST_GWID;
            end else begin
               state_in = vfm_pkg::ST_GGROW;
            end
         end
         vfm_pkg::ST_GGROW: begin
            mask_raddr = {vh[4:0], ui};
            j_in = 5'd0;
            if (vh[5]) begin
               i_in = 5'd0;
               state_in = vfm_pkg::ST_GCLR;
            end else begin
               state_in = vfm_pkg::ST_GGROWT;
            end
         end
         vfm_pkg::ST_GGROWT: begin
            if (mask_rdata != key_ff) begin
               i_in = 5'd0;
               state_in = vfm_pkg::ST_GCLR;
            end else if (ip1 == w_ff) begin
               h_in = h_ff + 6'd1;
               i_in = 5'd0;
               state_in = vfm_pkg::ST_GGROW;
            end else begin
               i_in = ip1[4:0];
               state_in = vfm_pkg::ST_GGROW;
            end
         end
         vfm_pkg::ST_GCLR: begin
            mask_we = 1'b1;
            mask_waddr = {v_ff + j_ff, ui};
            if (ip1 == w_ff) begin
               i_in = 5'd0;
               if (jp1 == h_ff) begin
                  em_in = 2'd0;
                  state_in = vfm_pkg::ST_EMIT;
               end else begin
                  j_in = jp1[4:0];
               end
            end else begin
               i_in = ip1[4:0];
            end
         end
         vfm_pkg::ST_EMIT: begin
            beat.face = face_ff;
            beat.corner = em_ff;
            beat.last_of_face = (em_ff == 2'd3);
            if (mode == vfm_pkg::MODE_GREEDY) begin
               beat.vert_x = vbase[0];
               beat.vert_y = vbase[1];
               beat.vert_z = vbase[2];
               beat.ao = key_ff[{em_ff, 1'b0} + 4'd4 +: 2];
               beat.material = key_ff[14:12];
               beat.color = key_ff[3:0];
            end else begin
               beat.vert_x = base[0];
               beat.vert_y = base[1];
               beat.vert_z = base[2];
               beat.ao = sig_ff[{em_ff, 1'b0} +: 2];
               beat.material = cv_ff[6:4];
               beat.color = cv_ff[3:0];
            end
            if (out_free) begin
               beat_valid = 1'b1;
               em_in = em_ff + 2'd1;
               if (em_ff == 2'd3) begin
                  state_in = vfm_pkg::ST_IDLE;
                  if (mode == vfm_pkg::MODE_GREEDY) begin
                     if (usum[5]) begin
                        u_in = 5'd0;
                        if (v_ff == 5'd31) begin
                           v_in = 5'd0;
                           mready_in = 1'b0;
                           if (slice_ff == 5'd31) begin
                              slice_in = 5'd0;
                              if (face_ff == 3'd5) begin
                                 face_in = 3'd0;
                                 fin_in = 1'b1;
                              end else begin
                                 face_in = face_ff + 3'd1;
                              end
                           end else begin
                              slice_in = slice_ff + 5'd1;
                           end
                        end else begin
                           v_in = v_ff + 5'd1;
                        end
                     end else begin
                        u_in = usum[4:0];
                     end
                  end else begin
                     if (face_ff == 3'd5) begin
                        face_in = 3'd0;
                        if (u_ff == 5'd31) begin
                           u_in = 5'd0;
                           if (row_ff == 5'd31) begin
                              row_in = 5'd0;
                              if (slice_ff == 5'd31) begin
                                 slice_in = 5'd0;
                                 fin_in = 1'b1;
                              end else begin
                                 slice_in = slice_ff + 5'd1;
                              end
                           end else begin
                              row_in = row_ff + 5'd1;
                           end
                        end else begin
                           u_in = u_ff + 5'd1;
                        end
                     end else begin
                        face_in = face_ff + 3'd1;
                     end
                  end
               end
            end
         end
         vfm_pkg::ST_DONE: begin
            beat.last_of_face = 1'b1;
            beat.done_res = 1'b1;
            if (out_free) begin
               beat_valid = 1'b1;
               state_in = vfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vfm_pkg::ST_IDLE;
         end
      endcase

      // A mode write restarts the walk.
      if (csr_we) begin
         face_in = '0;
         slice_in = '0;
         u_in = '0;
         v_in = '0;
         row_in = '0;
         fin_in = 1'b0;
         mready_in = 1'b0;
      end
   end

endmodule
